@@ design/bs_pkg.sv @@
package bs_pkg;

	localparam int KEY_W        = 32;
	localparam int SET_SIZE_DEF = 64;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic shift_in;
		logic pass_en;
		logic shift_out;
	} dp_cmd_t;

endpackage

@@ design/bs_ctrl.sv @@
module bs_ctrl
	import bs_pkg::*;
#(
	parameter int SET_SIZE = SET_SIZE_DEF,
	parameter int STAGES   = $clog2(SET_SIZE + 1) - 1,
	parameter int IW       = $clog2(SET_SIZE),
	parameter int SW       = (STAGES > 1) ? $clog2(STAGES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          last_key,
	output dp_cmd_t       cmd,
	output logic [SW-1:0] stage,
	output logic [SW-1:0] sh
);

	state_t        state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic [SW-1:0] stage_q, pass_q;
	logic          in_xfer, out_xfer, cnt_end, pass_end, stage_end;

	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid && !out_stall;
	assign cnt_end   = (cnt_q == IW'(SET_SIZE - 1));
	assign pass_end  = (pass_q == stage_q);
	assign stage_end = (stage_q == SW'(STAGES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && cnt_end) state_d = ST_SORT;
			end
			ST_SORT: begin
				if (pass_end && stage_end) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_xfer && cnt_end) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		in_stall      = 1'b1;
		out_valid     = 1'b0;
		cmd.pass_en   = 1'b0;
		case (state_q)
			ST_LOAD: in_stall    = 1'b0;
			ST_SORT: cmd.pass_en = 1'b1;
			ST_EMIT: out_valid   = 1'b1;
			default: in_stall    = 1'b1;
		endcase
		cmd.shift_in  = in_valid && !in_stall;
		cmd.shift_out = out_valid && !out_stall;
		last_key      = out_valid && cnt_end;
	end

	assign stage = stage_q;
	assign sh    = stage_q - pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			stage_q <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer || out_xfer) begin
				cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
			end
			if (state_q == ST_SORT) begin
				if (pass_end) begin
					pass_q  <= '0;
					stage_q <= stage_end ? '0 : stage_q + 1'b1;
				end else begin
					pass_q <= pass_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ design/bs_datapath.sv @@
module bs_datapath
	import bs_pkg::*;
#(
	parameter int SET_SIZE = SET_SIZE_DEF,
	parameter int STAGES   = $clog2(SET_SIZE + 1) - 1,
	parameter int SW       = (STAGES > 1) ? $clog2(STAGES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [SW-1:0]    stage,
	input  logic [SW-1:0]    sh,
	input  logic [KEY_W-1:0] key_in,
	input  logic             ascending_we,
	input  logic             ascending_wdata,
	output logic [KEY_W-1:0] key_out
);

	logic [KEY_W-1:0] keys_q   [SET_SIZE];
	logic [KEY_W-1:0] nxt_keys [SET_SIZE];
	logic             asc_q;

	// one compare-exchange slot per element, partner picked by the pass distance
	for (genvar gi = 0; gi < SET_SIZE; gi++) begin : g_elem
		logic [KEY_W-1:0] pv, mn, mx;
		logic             pok, lower, dbit, up;

		always_comb begin
			pv    = keys_q[gi];
			pok   = 1'b0;
			lower = 1'b0;
			dbit  = 1'b0;
			for (int k = 0; k < STAGES; k++) begin
				if (sh == SW'(k)) begin
					lower = (((gi >> k) & 1) == 0);
					if ((gi ^ (1 << k)) < SET_SIZE) begin
						pok = 1'b1;
						pv  = keys_q[(gi ^ (1 << k)) % SET_SIZE];
					end
				end
				if (stage == SW'(k)) begin
					dbit = (((gi >> (k + 1)) & 1) != 0);
				end
			end
			up = asc_q ^ dbit;
			if (pv < keys_q[gi]) begin
				mn = pv;
				mx = keys_q[gi];
			end else begin
				mn = keys_q[gi];
				mx = pv;
			end
		end

		assign nxt_keys[gi] = !pok ? keys_q[gi] : ((lower == up) ? mn : mx);
	end

	// keys shift in at the top and leave from entry zero
	always_ff @(posedge clk) begin
		if (cmd.pass_en) begin
			keys_q <= nxt_keys;
		end else if (cmd.shift_in || cmd.shift_out) begin
			for (int i = 0; i < SET_SIZE - 1; i++) begin
				keys_q[i] <= keys_q[i + 1];
			end
			if (cmd.shift_in) keys_q[SET_SIZE - 1] <= key_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asc_q <= 1'b1;
		end else if (ascending_we) begin
			asc_q <= ascending_wdata;
		end
	end

	assign key_out = keys_q[0];

endmodule

@@ design/bitonic_sorter_top.sv @@
// bitonic sorter: loads SET_SIZE keys one per cycle, sorts, then emits them in order
// the sort network passes run after the last key is loaded, before the first result is shown
// a new set is not accepted until the current set has been fully emitted
// set throughput is bounded by the serial load/emit shift line and one network pass per cycle
// reset: asynchronous active low, clears the controller and sets ascending to 1
// key storage is not reset; a set is always fully loaded before it is sorted
module bitonic_sorter_top
	import bs_pkg::*;
#(
	parameter int SET_SIZE = SET_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// input key channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [KEY_W-1:0] key_in,
	// sorted key channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [KEY_W-1:0] key_out,
	output logic             last_key,
	// ascending register write
	input  logic             ascending_we,
	input  logic             ascending_wdata
);

	// number of network stages, floor(log2(SET_SIZE))
	localparam int STAGES = $clog2(SET_SIZE + 1) - 1;
	// width of the load/emit counter index
	localparam int IW     = $clog2(SET_SIZE);
	// width of stage and pass distance codes
	localparam int SW     = (STAGES > 1) ? $clog2(STAGES) : 1;

	dp_cmd_t       cmd;
	logic [SW-1:0] stage;
	logic [SW-1:0] sh;

	// controller: load count, stage/pass sequencing, emit count and handshakes
	bs_ctrl #(
		.SET_SIZE (SET_SIZE),
		.STAGES   (STAGES),
		.IW       (IW),
		.SW       (SW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_key  (last_key),
		.cmd       (cmd),
		.stage     (stage),
		.sh        (sh)
	);

	// datapath: key row, compare-exchange slots and the direction register
	bs_datapath #(
		.SET_SIZE (SET_SIZE),
		.STAGES   (STAGES),
		.SW       (SW)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stage           (stage),
		.sh              (sh),
		.key_in          (key_in),
		.ascending_we    (ascending_we),
		.ascending_wdata (ascending_wdata),
		.key_out         (key_out)
	);

endmodule
